### rtl/core/cal_pkg.sv
package cal_pkg;

   // field widths
   localparam int unsigned DayW   = 5;
   localparam int unsigned MonthW = 4;
   localparam int unsigned YearW  = 14;

   // default year limits
   localparam int unsigned DefMinYear = 1900;
   localparam int unsigned DefMaxYear = 9999;

   // y / 100 = (y * 5243) >> 19, exact for every 14-bit y
   localparam int unsigned RecipW     = 13;
   localparam int unsigned RecipMul   = 5243;
   localparam int unsigned RecipShift = 19;
   localparam int unsigned ProdW      = YearW + RecipW;
   localparam int unsigned CentW      = 8;   // y / 100 <= 163
   localparam int unsigned Mod100W    = 7;

   // word widths
   localparam int unsigned ReqDataW = 24;
   localparam int unsigned RspDataW = 40;

   typedef logic [1:0]         cmd_type;
   typedef logic [DayW-1:0]    day_type;
   typedef logic [MonthW-1:0]  month_type;
   typedef logic [YearW-1:0]   year_type;
   typedef logic [Mod100W-1:0] mod100_type;

   localparam cmd_type CmdHold = 2'd0;
   localparam cmd_type CmdSet  = 2'd1;
   localparam cmd_type CmdNext = 2'd2;
   localparam cmd_type CmdPrev = 2'd3;

   localparam month_type MonthJan = 4'd1;
   localparam month_type MonthFeb = 4'd2;
   localparam month_type MonthDec = 4'd12;
   localparam day_type   DayFirst = 5'd1;
   localparam day_type   DayLast  = 5'd31;
   localparam mod100_type Mod100Top = 7'd99;

   // length of month m; months outside 1..12 count as 31 days
   function automatic day_type month_length(input month_type m, input logic leap);
      day_type len;
      unique case (m)
         4'd2:                     len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

   // Gregorian rule from y%4, y%100 and (y/100)%4
   function automatic logic leap_of(input logic [1:0] mod4, input mod100_type mod100,
                                    input logic [1:0] cent_mod4);
      return (mod4 == 2'd0) && ((mod100 != '0) || (cent_mod4 == 2'd0));
   endfunction

endpackage

### rtl/core/calendar_date_counter.sv
// Channel | Dir | Word                                   | Handshake
// req     | in  | tdata: day, month, year; tuser: cmd    | req_tvalid / req_tready
// rsp     | out | tdata: date, flags, days_in_month      | rsp_tvalid / rsp_tready
//
// One word accepted per cycle unless rsp_tready holds a valid result; each word passes through
// the input register, the divide-by-100 product register and the result register.
// The year is tracked with its residues mod 4, mod 100 and century mod 4, so no divider
// sits in the date step; constant multipliers (by 5243 and by 100) split a set year into century and rest.
// Reset loads 1/1/MIN_YEAR. rsp_tready low while a result is valid freezes every stage in place.
module calendar_date_counter
   import cal_pkg::*;
#(
   parameter int unsigned MIN_YEAR = DefMinYear,
   parameter int unsigned MAX_YEAR = DefMaxYear
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // day_in[4:0], month_in[8:5], year_in[22:9], 0
   input  logic [1:0]          req_tuser,  // cmd[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata   // day_out[4:0], month_out[8:5], year_out[22:9],
                                           // set_ok[23], limit_hit[24], leap_year[25],
                                           // days_in_month[30:26], is_greater[31],
                                           // is_equal[32], 0
);

   localparam year_type   MinYear     = year_type'(MIN_YEAR);
   localparam year_type   MaxYear     = year_type'(MAX_YEAR);
   localparam logic [1:0] MinMod4     = 2'(MIN_YEAR % 4);
   localparam mod100_type MinMod100   = Mod100W'(MIN_YEAR % 100);
   localparam logic [1:0] MinCentMod4 = 2'((MIN_YEAR / 100) % 4);

   logic adv;

   // stage 1: raw word
   logic      v1_ff;
   cmd_type   cmd1_ff;
   day_type   d1_ff;
   month_type m1_ff;
   year_type  y1_ff;

   // stage 2: word plus year / 100
   logic               v2_ff;
   cmd_type            cmd2_ff;
   day_type            d2_ff;
   month_type          m2_ff;
   year_type           y2_ff;
   logic [CentW-1:0]   q2_ff;
   logic [ProdW-1:0]   prod1;

   // date state and year residues
   day_type    day_ff, day_in;
   month_type  month_ff, month_in;
   year_type   year_ff, year_in;
   logic [1:0] mod4_ff, mod4_in;
   mod100_type mod100_ff, mod100_in;
   logic [1:0] cmod4_ff, cmod4_in;

   // result register
   logic                rsp_tvalid_ff;
   logic [RspDataW-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff         <= req_tvalid;
         v2_ff         <= v1_ff;
         rsp_tvalid_ff <= v2_ff;
      end
   end

   // payload stages
   assign prod1 = ProdW'(y1_ff) * ProdW'(RecipMul);

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff <= req_tuser;
         d1_ff   <= req_tdata[4:0];
         m1_ff   <= req_tdata[8:5];
         y1_ff   <= req_tdata[22:9];
         cmd2_ff <= cmd1_ff;
         d2_ff   <= d1_ff;
         m2_ff   <= m1_ff;
         y2_ff   <= y1_ff;
         q2_ff   <= prod1[RecipShift +: CentW];
      end
   end

   // set operand: remainder and leap
   logic [YearW-1:0] rem2_full;
   mod100_type       rem2;
   logic             in_leap, set_valid;

   assign rem2_full = y2_ff - YearW'(q2_ff) * YearW'(100);
   assign rem2      = rem2_full[Mod100W-1:0];
   assign in_leap   = leap_of(y2_ff[1:0], rem2, q2_ff[1:0]);
   assign set_valid = (y2_ff >= MinYear) && (y2_ff <= MaxYear)
                      && (m2_ff >= MonthJan) && (m2_ff <= MonthDec)
                      && (d2_ff >= DayFirst) && (d2_ff <= month_length(m2_ff, in_leap));

   // current stored date
   logic    cur_leap;
   day_type cur_len;
   assign cur_leap = leap_of(mod4_ff, mod100_ff, cmod4_ff);
   assign cur_len  = month_length(month_ff, cur_leap);

   logic set_ok, limit_hit;

   // date step
   always_comb begin
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      cmod4_in  = cmod4_ff;
      set_ok    = 1'b1;
      limit_hit = 1'b0;
      unique case (cmd2_ff)
         CmdSet: begin
            if (set_valid) begin
               day_in    = d2_ff;
               month_in  = m2_ff;
               year_in   = y2_ff;
               mod4_in   = y2_ff[1:0];
               mod100_in = rem2;
               cmod4_in  = q2_ff[1:0];
            end else begin
               day_in    = DayFirst;
               month_in  = MonthJan;
               year_in   = MinYear;
               mod4_in   = MinMod4;
               mod100_in = MinMod100;
               cmod4_in  = MinCentMod4;
               set_ok    = 1'b0;
            end
         end
         CmdNext: begin
            if (day_ff >= cur_len) begin
               if (month_ff >= MonthDec) begin
                  if (year_ff >= MaxYear) begin
                     limit_hit = 1'b1;
                  end else begin
                     day_in   = DayFirst;
                     month_in = MonthJan;
                     year_in  = year_ff + 1'b1;
                     mod4_in  = mod4_ff + 1'b1;
                     if (mod100_ff == Mod100Top) begin
                        mod100_in = '0;
                        cmod4_in  = cmod4_ff + 1'b1;
                     end else begin
                        mod100_in = mod100_ff + 1'b1;
                     end
                  end
               end else begin
                  day_in   = DayFirst;
                  month_in = month_ff + 1'b1;
               end
            end else begin
               day_in = day_ff + 1'b1;
            end
         end
         CmdPrev: begin
            if (day_ff <= DayFirst) begin
               if (month_ff <= MonthJan) begin
                  if (year_ff <= MinYear) begin
                     limit_hit = 1'b1;
                  end else begin
                     day_in   = DayLast;
                     month_in = MonthDec;
                     year_in  = year_ff - 1'b1;
                     mod4_in  = mod4_ff - 1'b1;
                     if (mod100_ff == '0) begin
                        mod100_in = Mod100Top;
                        cmod4_in  = cmod4_ff - 1'b1;
                     end else begin
                        mod100_in = mod100_ff - 1'b1;
                     end
                  end
               end else begin
                  month_in = month_ff - 1'b1;
                  day_in   = month_length(month_ff - 1'b1, cur_leap);
               end
            end else begin
               day_in = day_ff - 1'b1;
            end
         end
         default: begin
            // hold: date unchanged
         end
      endcase
   end

   // result word from the stepped date
   logic    new_leap, is_greater, is_equal;
   day_type new_len;
   assign new_leap   = leap_of(mod4_in, mod100_in, cmod4_in);
   assign new_len    = month_length(month_in, new_leap);
   assign is_equal   = (year_in == y2_ff) && (month_in == m2_ff) && (day_in == d2_ff);
   assign is_greater = (year_in > y2_ff)
                       || ((year_in == y2_ff) && (month_in > m2_ff))
                       || ((year_in == y2_ff) && (month_in == m2_ff) && (day_in > d2_ff));
   assign rsp_tdata_in = {7'd0, is_equal, is_greater, new_len, new_leap, limit_hit, set_ok,
                          year_in, month_in, day_in};

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff    <= DayFirst;
         month_ff  <= MonthJan;
         year_ff   <= MinYear;
         mod4_ff   <= MinMod4;
         mod100_ff <= MinMod100;
         cmod4_ff  <= MinCentMod4;
      end else if (adv && v2_ff) begin
         day_ff    <= day_in;
         month_ff  <= month_in;
         year_ff   <= year_in;
         mod4_ff   <= mod4_in;
         mod100_ff <= mod100_in;
         cmod4_ff  <= cmod4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v2_ff) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   // checks
   a_year_mod4: assert property (@(posedge clock) disable iff (reset)
      year_ff[1:0] == mod4_ff)
      else $error("year residue mod 4 out of step with year");

   a_set_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tdata_ff[23] |->
         rsp_tdata_ff[4:0] == DayFirst && rsp_tdata_ff[8:5] == MonthJan
         && rsp_tdata_ff[22:9] == MinYear)
      else $error("failed set did not fall back to first day of first year");

   a_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tdata_ff[24] |->
         (rsp_tdata_ff[4:0] == DayLast && rsp_tdata_ff[8:5] == MonthDec)
         || (rsp_tdata_ff[4:0] == DayFirst && rsp_tdata_ff[8:5] == MonthJan))
      else $error("limit flag away from a year boundary");

   a_feb_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tdata_ff[8:5] == MonthFeb |->
         rsp_tdata_ff[30:26] == (rsp_tdata_ff[25] ? 5'd29 : 5'd28))
      else $error("February length disagrees with leap flag");

endmodule
